/* rtl/free_block_allocator_unit_assert.svh */
// Assertion macros for the allocator RTL.
`ifndef FREE_BLOCK_ALLOCATOR_UNIT_ASSERT_SVH
`define FREE_BLOCK_ALLOCATOR_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define FBA_ASSERT_HOLDS(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define FBA_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/fba_pkg.sv */
`default_nettype none

package fba_pkg;

    localparam int WORD_W         = 32;
    localparam int WORD_SH        = 5;
    localparam int LEN_W          = 31;
    localparam int IDX_W          = 10;
    localparam int CNT_OUT_W      = 11;
    localparam int OP_W           = 3;
    localparam int STAT_W         = 3;
    localparam int LOG2_W         = 5;
    localparam int CFG_ADDR_W     = 1;
    localparam int CFG_DATA_W     = 11;
    localparam int BSIZE_LOG2_MAX = 30;

    localparam logic [CFG_DATA_W-1:0] BLOCK_COUNT_RST = 11'd1024;
    localparam logic [LOG2_W-1:0]     BSIZE_LOG2_RST  = 5'd20;

    localparam logic [OP_W-1:0] OP_ALLOC   = 3'd0;
    localparam logic [OP_W-1:0] OP_RESERVE = 3'd1;
    localparam logic [OP_W-1:0] OP_RELEASE = 3'd2;
    localparam logic [OP_W-1:0] OP_QUERY   = 3'd3;
    localparam logic [OP_W-1:0] OP_APPEND  = 3'd4;

    localparam logic [STAT_W-1:0] STAT_OK        = 3'd0;
    localparam logic [STAT_W-1:0] STAT_NO_SPACE  = 3'd1;
    localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 3'd2;
    localparam logic [STAT_W-1:0] STAT_BAD_LEN   = 3'd3;
    localparam logic [STAT_W-1:0] STAT_RANGE     = 3'd4;

    localparam logic [CFG_ADDR_W-1:0] REG_BLOCK_COUNT     = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_BLOCK_SIZE_LOG2 = 1'b1;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [IDX_W-1:0] block_index;
        logic [LEN_W-1:0] length;
    } req_t;

    typedef struct packed {
        logic [STAT_W-1:0]    status;
        logic [IDX_W-1:0]     granted_block;
        logic [LEN_W-1:0]     written_bytes;
        logic [CNT_OUT_W-1:0] allocated_count;
    } rsp_t;

    // Decision of one evaluate step, from the shared unit to the sequencer.
    typedef struct packed {
        logic                 fin;
        logic [STAT_W-1:0]    status;
        logic [IDX_W-1:0]     granted;
        logic [WORD_SH-1:0]   bit_pos;
        logic [LEN_W-1:0]     wbytes;
        logic                 map_we;
        logic [WORD_W-1:0]    map_wdata;
        logic                 len_we;
        logic [LEN_W-1:0]     len_wdata;
        logic                 inc;
        logic                 dec;
    } eval_t;

endpackage

`default_nettype wire

/* rtl/free_block_allocator_unit.sv */
// Reserve, release, query, append and rejected requests take a read and then an evaluate step
// before m_valid; allocate repeats both for each 32-block map word scanned (1..ceil(NUM_BLOCKS/32)).
// Evaluate waits while the last result is still held. One request in flight, set by the
// read-then-evaluate loop around the single-port free-map RAM; s_ready is low until it ends.
// Reset: synchronous, active low. Afterwards the free map is swept to all-free, one word a
// cycle, with s_ready low until the last word is written.
`default_nettype none
`include "free_block_allocator_unit_assert.svh"

module free_block_allocator_unit #(
    parameter int NUM_BLOCKS      = 1024,
    parameter int PAGE_BYTES_LOG2 = 12
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  fba_pkg::req_t                  s_req,
    output logic                           m_valid,
    input  logic                           m_ready,
    output fba_pkg::rsp_t                  m_rsp,
    input  logic                           cfg_we,
    input  logic [fba_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [fba_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    import fba_pkg::*;

    // Free map is held as 32-bit words, one bit per block (1 = free).
    localparam int NUM_WORDS = (NUM_BLOCKS + WORD_W - 1) / WORD_W;
    localparam int WA_W      = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int LA_W      = $clog2(NUM_BLOCKS);
    localparam int CNT_W     = $clog2(NUM_BLOCKS + 1);

    // Sequencer states: sweep the map, wait for a request, read, evaluate.
    localparam logic [1:0] S_CLR  = 2'd0;
    localparam logic [1:0] S_IDLE = 2'd1;
    localparam logic [1:0] S_RD   = 2'd2;
    localparam logic [1:0] S_EV   = 2'd3;

    logic [1:0]            state_reg, state_next;
    logic [WA_W-1:0]       word_reg, word_next;
    req_t                  req_reg, req_next;
    logic [CNT_W-1:0]      count_reg, count_next, count_upd;
    logic                  m_valid_reg, m_valid_next;
    rsp_t                  rsp_reg, rsp_next;
    logic [CFG_DATA_W-1:0] blk_count_reg;
    logic [LOG2_W-1:0]     bsize_log2_reg;

    logic [31:0]           cnt_eff;
    logic [LOG2_W-1:0]     size_log2;
    logic [LEN_W-1:0]      bsz;
    logic [31:0]           idx_ext;
    logic [31:0]           word_base;
    logic                  in_range;
    logic                  last_word;
    logic                  is_alloc;
    logic                  out_free;
    logic                  fire;
    eval_t                 ev;

    logic                  map_we;
    logic [WA_W-1:0]       map_addr;
    logic [WORD_W-1:0]     map_wdata;
    logic [WORD_W-1:0]     map_rdata;
    logic                  len_we;
    logic [LA_W-1:0]       len_raddr;
    logic [LA_W-1:0]       len_waddr;
    logic [LEN_W-1:0]      len_rdata;

    // Effective configuration: clamp count to the map size, block size to [page, 2^30].
    assign cnt_eff = (32'(blk_count_reg) < 32'(NUM_BLOCKS)) ? 32'(blk_count_reg)
                                                           : 32'(NUM_BLOCKS);
    always_comb begin
        size_log2 = bsize_log2_reg;
        if (bsize_log2_reg < LOG2_W'(PAGE_BYTES_LOG2)) begin
            size_log2 = LOG2_W'(PAGE_BYTES_LOG2);
        end else if (bsize_log2_reg > LOG2_W'(BSIZE_LOG2_MAX)) begin
            size_log2 = LOG2_W'(BSIZE_LOG2_MAX);
        end
    end
    assign bsz = LEN_W'(1) << size_log2;

    assign idx_ext   = 32'(req_reg.block_index);
    assign in_range  = idx_ext < cnt_eff;
    assign is_alloc  = req_reg.op == OP_ALLOC;
    assign word_base = 32'(word_reg) << WORD_SH;
    assign last_word = word_reg == WA_W'(NUM_WORDS - 1);

    // Hold the result register until it is taken; evaluate only into a free slot.
    assign out_free = !m_valid_reg || m_ready;
    assign fire     = (state_reg == S_EV) && out_free;

    // Free map: scan address for allocate, block's word otherwise. Sweep writes all ones.
    assign map_addr  = (state_reg == S_CLR || is_alloc) ? word_reg
                                                        : WA_W'(idx_ext >> WORD_SH);
    assign map_we    = (state_reg == S_CLR) || (fire && ev.map_we);
    assign map_wdata = (state_reg == S_CLR) ? '1 : ev.map_wdata;

    // Written lengths: allocate writes the chosen block, other ops the addressed one.
    assign len_raddr = LA_W'(idx_ext);
    assign len_waddr = is_alloc ? LA_W'(word_base + 32'(ev.bit_pos)) : len_raddr;
    assign len_we    = fire && ev.len_we;

    fba_ram #(
        .WIDTH (WORD_W),
        .DEPTH (NUM_WORDS)
    ) u_map_ram (
        .aclk  (aclk),
        .we    (map_we),
        .waddr (map_addr),
        .wdata (map_wdata),
        .raddr (map_addr),
        .rdata (map_rdata)
    );

    fba_ram #(
        .WIDTH (LEN_W),
        .DEPTH (NUM_BLOCKS)
    ) u_len_ram (
        .aclk  (aclk),
        .we    (len_we),
        .waddr (len_waddr),
        .wdata (ev.len_wdata),
        .raddr (len_raddr),
        .rdata (len_rdata)
    );

    // Shared evaluate unit: priority pick, bound compares and length add.
    fba_unit #(
        .PAGE_BYTES_LOG2 (PAGE_BYTES_LOG2)
    ) u_unit (
        .op          (req_reg.op),
        .block_index (req_reg.block_index),
        .length      (req_reg.length),
        .in_range    (in_range),
        .map_word    (map_rdata),
        .wlen        (len_rdata),
        .bsz         (bsz),
        .word_base   (word_base),
        .cnt_eff     (cnt_eff),
        .last_word   (last_word),
        .ev          (ev)
    );

    always_comb begin
        count_upd = count_reg;
        if (ev.inc) begin
            count_upd = count_reg + 1'b1;
        end else if (ev.dec) begin
            count_upd = count_reg - 1'b1;
        end
    end

    always_comb begin
        state_next   = state_reg;
        word_next    = word_reg;
        req_next     = req_reg;
        count_next   = count_reg;
        m_valid_next = m_valid_reg;
        rsp_next     = rsp_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            S_CLR: begin
                // Advance the sweep; drop into idle after the last word.
                word_next = word_reg + 1'b1;
                if (last_word) begin
                    word_next  = '0;
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    req_next   = s_req;
                    word_next  = '0;
                    state_next = S_RD;
                end
            end
            S_RD: begin
                // RAM read issued this cycle; data is registered for the evaluate step.
                state_next = S_EV;
            end
            S_EV: begin
                if (fire) begin
                    if (ev.fin) begin
                        count_next                = count_upd;
                        rsp_next.status           = ev.status;
                        rsp_next.granted_block    = ev.granted;
                        rsp_next.written_bytes    = ev.wbytes;
                        rsp_next.allocated_count  = CNT_OUT_W'(32'(count_upd));
                        m_valid_next              = 1'b1;
                        state_next                = S_IDLE;
                    end else begin
                        // No free block in this word: advance to the next one.
                        word_next  = word_reg + 1'b1;
                        state_next = S_RD;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLR;
            word_reg    <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            word_reg    <= word_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg <= req_next;
        rsp_reg <= rsp_next;
    end

    // Configuration writes; the user must write only while idle, the block itself does not enforce it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            blk_count_reg  <= BLOCK_COUNT_RST;
            bsize_log2_reg <= BSIZE_LOG2_RST;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_BLOCK_COUNT: begin
                    blk_count_reg <= cfg_wdata;
                end
                REG_BLOCK_SIZE_LOG2: begin
                    bsize_log2_reg <= cfg_wdata[LOG2_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign s_ready = state_reg == S_IDLE;
    assign m_valid = m_valid_reg;
    assign m_rsp   = rsp_reg;

    `FBA_ASSERT_HOLDS(a_count_bound, aclk, aresetn, 1'b1, 32'(count_reg) <= 32'(NUM_BLOCKS), "allocated count past the block total")
    `FBA_ASSERT_HOLDS(a_map_write_state, aclk, aresetn, map_we, (state_reg == S_CLR) || (state_reg == S_EV), "free map written outside sweep or evaluate")
    `FBA_ASSERT_NEXT(a_result_posted, aclk, aresetn, fire && ev.fin, m_valid_reg, "finished request did not post a result")
    `FBA_ASSERT_NEXT(a_grant_counts, aclk, aresetn, fire && ev.inc, count_reg == $past(count_reg) + 1'b1, "grant did not bump the allocated count")

endmodule

`default_nettype wire

/* rtl/fba_ram.sv */
`default_nettype none

module fba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* rtl/fba_unit.sv */
`default_nettype none

module fba_unit #(
    parameter int PAGE_BYTES_LOG2 = 12
) (
    input  logic [fba_pkg::OP_W-1:0]   op,
    input  logic [fba_pkg::IDX_W-1:0]  block_index,
    input  logic [fba_pkg::LEN_W-1:0]  length,
    input  logic                       in_range,
    input  logic [fba_pkg::WORD_W-1:0] map_word,
    input  logic [fba_pkg::LEN_W-1:0]  wlen,
    input  logic [fba_pkg::LEN_W-1:0]  bsz,
    input  logic [31:0]                word_base,
    input  logic [31:0]                cnt_eff,
    input  logic                       last_word,
    output fba_pkg::eval_t             ev
);

    import fba_pkg::*;

    localparam logic [LEN_W-1:0] SUBPAGE_BITS = LEN_W'((64'd1 << PAGE_BYTES_LOG2) - 64'd1);

    logic [WORD_SH-1:0] sel_bit;
    logic [WORD_SH-1:0] pos;
    logic               any_free;
    logic [31:0]        alloc_blk;
    logic               aligned;
    logic               sel_free;
    logic [LEN_W:0]     sum;

    assign sel_bit   = block_index[WORD_SH-1:0];
    assign sel_free  = map_word[sel_bit];
    assign aligned   = (length & SUBPAGE_BITS) == '0;
    assign sum       = {1'b0, wlen} + {1'b0, length};
    assign alloc_blk = word_base + 32'(pos);

    // Lowest set bit of the map word.
    always_comb begin
        pos      = '0;
        any_free = 1'b0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (map_word[i]) begin
                pos      = WORD_SH'(i);
                any_free = 1'b1;
            end
        end
    end

    always_comb begin
        ev           = '0;
        ev.fin       = 1'b1;
        ev.status    = STAT_OK;
        ev.granted   = block_index;
        ev.bit_pos   = sel_bit;
        ev.map_wdata = map_word;
        if (op == OP_ALLOC) begin
            ev.bit_pos = pos;
            ev.granted = '0;
            if (any_free && (alloc_blk < cnt_eff)) begin
                ev.granted   = IDX_W'(alloc_blk);
                ev.map_we    = 1'b1;
                ev.map_wdata = map_word & ~(WORD_W'(1) << pos);
                ev.len_we    = 1'b1;
                ev.inc       = 1'b1;
            end else begin
                ev.status = STAT_NO_SPACE;
                ev.fin    = any_free || last_word || ((word_base + 32'(WORD_W)) >= cnt_eff);
            end
        end else if (!in_range) begin
            ev.status = STAT_RANGE;
        end else begin
            case (op)
                OP_RESERVE: begin
                    if (!sel_free) begin
                        ev.status = STAT_NOT_FOUND;
                        ev.wbytes = wlen;
                    end else if (!aligned || (length > bsz)) begin
                        ev.status = STAT_BAD_LEN;
                    end else begin
                        ev.map_we    = 1'b1;
                        ev.map_wdata = map_word & ~(WORD_W'(1) << sel_bit);
                        ev.len_we    = 1'b1;
                        ev.len_wdata = length;
                        ev.inc       = 1'b1;
                        ev.wbytes    = length;
                    end
                end
                OP_RELEASE: begin
                    if (sel_free) begin
                        ev.status = STAT_NOT_FOUND;
                    end else begin
                        ev.map_we    = 1'b1;
                        ev.map_wdata = map_word | (WORD_W'(1) << sel_bit);
                        ev.dec       = 1'b1;
                    end
                end
                OP_QUERY: begin
                    if (sel_free) begin
                        ev.status = STAT_NOT_FOUND;
                    end else begin
                        ev.wbytes = wlen;
                    end
                end
                OP_APPEND: begin
                    if (sel_free) begin
                        ev.status = STAT_NOT_FOUND;
                    end else if (!aligned || (sum > {1'b0, bsz})) begin
                        ev.status = STAT_BAD_LEN;
                        ev.wbytes = wlen;
                    end else begin
                        ev.len_we    = 1'b1;
                        ev.len_wdata = sum[LEN_W-1:0];
                        ev.wbytes    = sum[LEN_W-1:0];
                    end
                end
                default: begin
                    ev.status = STAT_RANGE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

/* tb/testbench.sv */
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import fba_pkg::*;

    // Opcodes the block does not define; it must answer them with out_of_range.
    localparam logic [OP_W-1:0] OP_RSVD5 = 3'd5;
    localparam logic [OP_W-1:0] OP_RSVD6 = 3'd6;
    localparam logic [OP_W-1:0] OP_RSVD7 = 3'd7;

    localparam logic [31:0] PAGE_BYTES  = 32'd4096;
    localparam int          PHASE_ITEMS = 230;
    localparam int          STALL_LIMIT = 5000;   // cycles without any handshake
    localparam int          HOLD_CYCLES = 400;    // long receiver hold-off
    localparam int          HOLD_PHASE  = 4;

    // Mirror of the allocator: free map, written lengths, allocated count and
    // the two registers. Requests go in as they are accepted, responses are
    // checked against the oldest prediction.
    class alloc_scoreboard;
        localparam int BLOCKS    = 1024;
        localparam int PAGE_LOG2 = 12;
        localparam int SIZE_MAX  = 30;

        bit                   free_map[BLOCKS];
        logic [LEN_W-1:0]     wlen[BLOCKS];
        int unsigned          in_use;
        logic [CFG_DATA_W-1:0] count_reg;
        logic [LOG2_W-1:0]    size_log2_reg;
        rsp_t                 predicted_q[$];
        int                   errors;
        int                   requests;
        int                   responses;
        int                   reg_writes;
        int                   status_seen[5];

        function new();
            foreach (free_map[i]) free_map[i] = 1'b1;
            in_use        = 0;
            count_reg     = BLOCK_COUNT_RST;
            size_log2_reg = BSIZE_LOG2_RST;
            errors        = 0;
            requests      = 0;
            responses     = 0;
            reg_writes    = 0;
            foreach (status_seen[i]) status_seen[i] = 0;
        endfunction

        function int unsigned eff_count();
            return (count_reg < BLOCKS) ? int'(count_reg) : BLOCKS;
        endfunction

        function logic [31:0] block_bytes();
            int unsigned s;
            s = size_log2_reg;
            if (s < PAGE_LOG2) s = PAGE_LOG2;
            if (s > SIZE_MAX) s = SIZE_MAX;
            return 32'd1 << s;
        endfunction

        function int pending();
            return predicted_q.size();
        endfunction

        function void write_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
            if (addr == REG_BLOCK_COUNT) count_reg = data;
            else size_log2_reg = data[LOG2_W-1:0];
            reg_writes++;
        endfunction

        function void note_request(req_t r);
            rsp_t         e;
            int unsigned  cnt;
            int unsigned  i;
            logic [31:0]  bsz;
            logic [31:0]  sum;
            bit           in_range;
            bit           aligned;
            cnt      = eff_count();
            bsz      = block_bytes();
            in_range = r.block_index < cnt;
            aligned  = r.length[PAGE_LOG2-1:0] == '0;
            e.status          = STAT_OK;
            e.granted_block   = r.block_index;
            e.written_bytes   = '0;
            if (r.op == OP_ALLOC) begin
                e.status        = STAT_NO_SPACE;
                e.granted_block = '0;
                for (i = 0; i < cnt; i++) begin
                    if (free_map[i]) begin
                        free_map[i]     = 1'b0;
                        wlen[i]         = '0;
                        in_use++;
                        e.status        = STAT_OK;
                        e.granted_block = i[IDX_W-1:0];
                        break;
                    end
                end
            end else if (r.op > OP_APPEND || !in_range) begin
                e.status = STAT_RANGE;
            end else if (r.op == OP_RESERVE) begin
                if (!free_map[r.block_index]) begin
                    e.status = STAT_NOT_FOUND;
                end else if (!aligned || r.length > bsz) begin
                    e.status = STAT_BAD_LEN;
                end else begin
                    free_map[r.block_index] = 1'b0;
                    wlen[r.block_index]     = r.length;
                    in_use++;
                end
            end else if (free_map[r.block_index]) begin
                e.status = STAT_NOT_FOUND;
            end else if (r.op == OP_RELEASE) begin
                free_map[r.block_index] = 1'b1;
                wlen[r.block_index]     = '0;
                in_use--;
            end else if (r.op == OP_APPEND) begin
                sum = {1'b0, wlen[r.block_index]} + {1'b0, r.length};
                if (!aligned || sum > bsz) e.status = STAT_BAD_LEN;
                else wlen[r.block_index] = sum[LEN_W-1:0];
            end

            if (r.op == OP_ALLOC) begin
                if (e.status == STAT_OK) e.written_bytes = wlen[e.granted_block];
            end else if (r.op <= OP_APPEND && in_range && !free_map[r.block_index]) begin
                e.written_bytes = wlen[r.block_index];
            end
            e.allocated_count = in_use[CNT_OUT_W-1:0];
            status_seen[e.status]++;
            requests++;
            predicted_q.push_back(e);
        endfunction

        function void check_result(rsp_t got);
            rsp_t e;
            responses++;
            if (predicted_q.size() == 0) begin
                $error("response with no request outstanding: %p", got);
                errors++;
                return;
            end
            e = predicted_q.pop_front();
            if (got.status !== e.status) begin
                $error("status: expected %0d, got %0d", e.status, got.status);
                errors++;
            end
            if (got.granted_block !== e.granted_block) begin
                $error("granted_block: expected %0d, got %0d", e.granted_block,
                       got.granted_block);
                errors++;
            end
            if (got.written_bytes !== e.written_bytes) begin
                $error("written_bytes: expected %0d, got %0d", e.written_bytes,
                       got.written_bytes);
                errors++;
            end
            if (got.allocated_count !== e.allocated_count) begin
                $error("allocated_count: expected %0d, got %0d", e.allocated_count,
                       got.allocated_count);
                errors++;
            end
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    req_t                  s_req     = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    rsp_t                  m_rsp;
    logic                  cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    alloc_scoreboard sb = new();

    // Idle knobs, percent per cycle; hold_off is a one-shot long stall on the
    // response side that the receiver counts down itself.
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_off       = 0;
    int quiet_cycles   = 0;

    // Register settings per random phase: min, max and clamped values of both.
    int unsigned phase_count[8] = '{1024, 16, 1, 2047, 40, 300, 1024, 8};
    int unsigned phase_log2[8]  = '{20, 12, 30, 31, 3, 16, 25, 13};

    free_block_allocator_unit DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_req     (s_req),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_rsp     (m_rsp),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Sample every handshake with pre-edge values: register writes first so a
    // request never sees a stale setting, then requests, then responses.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_we) sb.write_reg(cfg_addr, cfg_wdata);
            if (s_valid && s_ready) sb.note_request(s_req);
            if (m_valid && m_ready) sb.check_result(m_rsp);
        end
    end

    // Receiver: stall at random, or hold off for a long stretch when asked.
    always @(posedge aclk) begin
        if (hold_off > 0) begin
            m_ready  <= 1'b0;
            hold_off <= hold_off - 1;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Watchdog: any handshake or register write counts as progress.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_we || !aresetn) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles + 1 >= STALL_LIMIT) begin
                $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    function automatic req_t request_of(logic [OP_W-1:0] op, int unsigned idx,
                                        logic [31:0] len);
        req_t r;
        r.op          = op;
        r.block_index = idx[IDX_W-1:0];
        r.length      = len[LEN_W-1:0];
        return r;
    endfunction

    // Build one random request. Most indices land in range and, where the
    // operation needs it, on a block in the right state, so that appends and
    // releases do real work; lengths favor small page multiples and the exact
    // room left, with unaligned and arbitrary values mixed in.
    function automatic req_t draw_request();
        req_t        r;
        int unsigned cnt;
        int unsigned roll;
        int unsigned tries;
        logic [31:0] bsz;
        logic [31:0] room;
        bit          want_free;
        cnt  = sb.eff_count();
        bsz  = sb.block_bytes();
        roll = $urandom_range(0, 99);
        if (roll < 22)      r.op = OP_ALLOC;
        else if (roll < 40) r.op = OP_RESERVE;
        else if (roll < 56) r.op = OP_RELEASE;
        else if (roll < 70) r.op = OP_QUERY;
        else if (roll < 95) r.op = OP_APPEND;
        else                r.op = OP_W'($urandom_range(OP_RSVD5, OP_RSVD7));

        want_free = (r.op == OP_RESERVE);
        roll      = $urandom_range(0, 9);
        if (roll == 0) begin
            r.block_index = IDX_W'($urandom());
        end else begin
            r.block_index = IDX_W'($urandom_range(0, cnt - 1));
            if (roll < 7) begin
                for (tries = 0; tries < 8 && sb.free_map[r.block_index] != want_free;
                     tries++) begin
                    r.block_index = IDX_W'($urandom_range(0, cnt - 1));
                end
            end
        end

        if (r.op == OP_RESERVE || sb.free_map[r.block_index]) room = bsz;
        else room = bsz - {1'b0, sb.wlen[r.block_index]};

        case ($urandom_range(0, 9))
            0:       r.length = LEN_W'($urandom());
            1:       r.length = room[LEN_W-1:0];
            2:       r.length = room[LEN_W-1:0] + PAGE_BYTES[LEN_W-1:0];
            3:       r.length = LEN_W'(($urandom_range(0, 16) << 12) | $urandom_range(1, 4095));
            default: r.length = LEN_W'($urandom_range(0, 8) << 12);
        endcase
        return r;
    endfunction

    // Offer one request, idling first as the sender knob says. Valid stays up
    // into the next request when no gap is drawn.
    task automatic send_request(input req_t r);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_req   <= r;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // Drop valid, step past the last accept so it is on the books, then wait
    // for every outstanding response plus a few cycles.
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Write both registers back to back; the block must be idle here.
    task automatic set_config(input int unsigned count, input int unsigned log2);
        cfg_we    <= 1'b1;
        cfg_addr  <= REG_BLOCK_COUNT;
        cfg_wdata <= count[CFG_DATA_W-1:0];
        @(posedge aclk);
        cfg_addr  <= REG_BLOCK_SIZE_LOG2;
        cfg_wdata <= log2[CFG_DATA_W-1:0];
        @(posedge aclk);
        cfg_we    <= 1'b0;
    endtask

    // Idle modes: none, sender mostly idle, receiver mostly stalled, light on both.
    task automatic set_idle(input int mode);
        case (mode % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 72; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 72; end
            default: begin send_idle_pct = 14; recv_stall_pct = 14; end
        endcase
    endtask

    initial begin
        int p;
        int n;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed, reset settings (1024 blocks of 1 MiB): allocate lowest,
        // reserve at the size limit and past it, unaligned lengths, appends
        // that fit exactly and overflow, operations on free blocks, and the
        // undefined opcodes, two of them with every length bit set.
        send_request(request_of(OP_ALLOC, 0, 0));
        send_request(request_of(OP_ALLOC, 1023, 0));
        send_request(request_of(OP_RESERVE, 5, PAGE_BYTES));
        send_request(request_of(OP_RESERVE, 5, 0));
        send_request(request_of(OP_RESERVE, 6, PAGE_BYTES - 1));
        send_request(request_of(OP_RESERVE, 6, 32'h0010_1000));
        send_request(request_of(OP_RESERVE, 1023, 32'h0010_0000));
        send_request(request_of(OP_APPEND, 1023, 0));
        send_request(request_of(OP_APPEND, 1023, PAGE_BYTES));
        send_request(request_of(OP_APPEND, 5, 2 * PAGE_BYTES));
        send_request(request_of(OP_APPEND, 5, 100));
        send_request(request_of(OP_QUERY, 5, 0));
        send_request(request_of(OP_QUERY, 7, 0));
        send_request(request_of(OP_RELEASE, 7, 0));
        send_request(request_of(OP_APPEND, 7, PAGE_BYTES));
        send_request(request_of(OP_RELEASE, 5, 0));
        send_request(request_of(OP_RSVD5, 1023, 32'h7FFF_FFFF));
        send_request(request_of(OP_RSVD6, 0, 32'h7FFF_FFFF));
        send_request(request_of(OP_RSVD7, 512, 0));
        drain();

        // Directed, shrunk to three blocks of 1 GiB: exhaust the space, address
        // a block still allocated past the count, reserve a full-size block.
        set_config(3, 30);
        send_request(request_of(OP_ALLOC, 0, 0));
        send_request(request_of(OP_ALLOC, 0, 0));
        send_request(request_of(OP_QUERY, 1023, 0));
        send_request(request_of(OP_RESERVE, 3, 0));
        send_request(request_of(OP_RELEASE, 2, 0));
        send_request(request_of(OP_RESERVE, 2, 32'h4000_0000));
        send_request(request_of(OP_APPEND, 2, PAGE_BYTES));
        drain();

        // Random phases, each with its own register setting and idle mode.
        for (p = 0; p < 8; p++) begin
            set_config(phase_count[p], phase_log2[p]);
            set_idle(p);
            for (n = 0; n < PHASE_ITEMS; n++) begin
                // Hold responses back while requests keep coming so the
                // block backs up and stalls its input.
                if (p == HOLD_PHASE && n == PHASE_ITEMS / 2) hold_off = HOLD_CYCLES;
                send_request(draw_request());
            end
            drain();
        end

        $display("Ran %0d requests and %0d responses across %0d register writes",
                 sb.requests, sb.responses, sb.reg_writes);
        $display("  ok %0d, no_space %0d, not_found %0d, invalid_length %0d, out_of_range %0d",
                 sb.status_seen[STAT_OK], sb.status_seen[STAT_NO_SPACE],
                 sb.status_seen[STAT_NOT_FOUND], sb.status_seen[STAT_BAD_LEN],
                 sb.status_seen[STAT_RANGE]);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
